// File: hw/rtl/packet_sender_block_filter_defines.svh
// Assertion macros for the port-level checker of the sender block filter.
// No dependencies; the user provides clock and reset signals in scope.
`ifndef PACKET_SENDER_BLOCK_FILTER_DEFINES_SVH
`define PACKET_SENDER_BLOCK_FILTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PBF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbf assertion failed");

// next-cycle implication, disabled in reset
`define PBF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbf assertion failed");

// next-cycle implication, also checked across reset
`define PBF_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("pbf assertion failed");

`endif

// File: hw/rtl/pbf_pkg.sv
// Package of the sender block filter: field widths, codes and reset values.
// No dependencies; used by the interfaces, the top level and the checker.
package pbf_pkg;

   localparam int DefMaxEntries = 9;

   localparam int KindW   = 2;
   localparam int TagW    = 16;
   localparam int AddrW   = 8;
   localparam int ByteW   = 8;
   localparam int StatusW = 4;
   localparam int SizeW   = 4;
   localparam int CntW    = 16;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 16;

   typedef logic [KindW-1:0]    kind_type;
   typedef logic [StatusW-1:0]  status_type;
   typedef logic [CsrIdxW-1:0]  csr_idx_type;

   localparam kind_type KIND_PACKET = 2'd0;
   localparam kind_type KIND_ADD    = 2'd1;
   localparam kind_type KIND_REMOVE = 2'd2;

   localparam status_type ST_FOREIGN   = 4'd0;
   localparam status_type ST_DELIVERED = 4'd1;
   localparam status_type ST_OVERRIDE  = 4'd2;
   localparam status_type ST_BLOCKED   = 4'd3;
   localparam status_type ST_ADDED     = 4'd4;
   localparam status_type ST_DUPLICATE = 4'd5;
   localparam status_type ST_FULL      = 4'd6;
   localparam status_type ST_REMOVED   = 4'd7;
   localparam status_type ST_ABSENT    = 4'd8;

   localparam csr_idx_type CSR_OWN_ADDR   = 3'd0;
   localparam csr_idx_type CSR_NETWORK_ID = 3'd1;
   localparam csr_idx_type CSR_CMD_TYPE   = 3'd2;
   localparam csr_idx_type CSR_ACK_TYPE   = 3'd3;
   localparam csr_idx_type CSR_UNBLOCK    = 3'd4;

   localparam logic [ByteW-1:0] NET_ID_HIGH = 8'haf;
   localparam logic [ByteW-1:0] NET_ID_LOW  = 8'hfe;
   localparam logic [TagW-1:0]  NET_ID_RESET = {NET_ID_HIGH, NET_ID_LOW};

endpackage

// File: hw/rtl/pbf_if.sv
// Request and response channel interfaces of the sender block filter.
// Depends on pbf_pkg for field widths.
interface pbf_req_if import pbf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KindW-1:0]    kind;
   logic [TagW-1:0]     net_tag;
   logic [AddrW-1:0]    node_addr;
   logic [AddrW-1:0]    dest_addr;
   logic [ByteW-1:0]    pkt_type;
   logic [ByteW-1:0]    first_payload;

   modport source (output valid, kind, net_tag, node_addr, dest_addr, pkt_type,
                   first_payload, input ready);
   modport sink   (input valid, kind, net_tag, node_addr, dest_addr, pkt_type,
                   first_payload, output ready);
endinterface

interface pbf_rsp_if import pbf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [StatusW-1:0]  status;
   logic                deliver;
   logic [SizeW-1:0]    list_size;
   logic [CntW-1:0]     received_total;

   modport source (output valid, status, deliver, list_size, received_total, input ready);
   modport sink   (input valid, status, deliver, list_size, received_total, output ready);
endinterface

// File: hw/rtl/packet_sender_block_filter.sv
// Sender block filter: one request in, one response out, list kept in a registered-read RAM.
// Depends on pbf_pkg and the channel interfaces in pbf_if.sv.
// A packet or add reads the list one entry at a time and stops on a match; a remove then
// shifts each later entry down with a read and a write. One request at a time: a new
// request is taken only after the previous response is loaded into the output register.
// Reset: synchronous; clears list size, packet counter, config to defaults, no RAM sweep.
module packet_sender_block_filter
   import pbf_pkg::*;
#(
   parameter int MAX_ENTRIES = DefMaxEntries
) (
   input  logic                 clock,
   input  logic                 reset,
   pbf_req_if.sink              req_ch,
   pbf_rsp_if.source            rsp_ch,
   input  logic                 csr_we,
   input  logic [CsrIdxW-1:0]   csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_SHIFT_WR, S_DONE} state_type;

   state_type           state_ff;

   logic [AddrW-1:0]    own_addr_ff;
   logic [TagW-1:0]     net_id_ff;
   logic [ByteW-1:0]    cmd_type_ff;
   logic [ByteW-1:0]    ack_type_ff;
   logic [ByteW-1:0]    unblock_ff;

   logic [KindW-1:0]    kind_ff;
   logic [TagW-1:0]     tag_ff;
   logic [AddrW-1:0]    key_ff;
   logic [AddrW-1:0]    dest_ff;
   logic [ByteW-1:0]    ptype_ff;
   logic [ByteW-1:0]    pay0_ff;

   logic [CNT_W-1:0]    count_ff;
   logic [CntW-1:0]     pkt_cnt_ff;
   logic [CNT_W-1:0]    cmp_idx_ff;
   logic [CNT_W-1:0]    sh_idx_ff;
   status_type          res_status_ff;
   logic                res_deliver_ff;

   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic                rsp_deliver_ff;
   logic [SizeW-1:0]    rsp_size_ff;
   logic [CntW-1:0]     rsp_total_ff;

   logic [AddrW-1:0]    mem [MAX_ENTRIES];
   logic [AddrW-1:0]    mem_q_ff;
   logic [CNT_W-1:0]    rd_addr;
   logic                mem_we;
   logic [CNT_W-1:0]    mem_waddr;
   logic [AddrW-1:0]    mem_wdata;

   logic                req_fire;
   logic                scan_end;
   logic                found;
   logic                override_ok;
   logic                out_free;
   logic [CNT_W+SizeW-1:0] size_ext;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign found       = (cmp_idx_ff < count_ff) && (mem_q_ff == key_ff);
   assign scan_end    = (cmp_idx_ff >= count_ff) || found;
   assign override_ok = (dest_ff == own_addr_ff) &&
                        ((ptype_ff == cmd_type_ff) || (ptype_ff == ack_type_ff)) &&
                        (pay0_ff == unblock_ff);
   assign size_ext    = {{SizeW{1'b0}}, count_ff};

   // RAM port control
   always_comb begin
      rd_addr   = '0;
      mem_we    = 1'b0;
      mem_waddr = count_ff;
      mem_wdata = key_ff;
      unique case (state_ff)
         S_SCAN: begin
            rd_addr = cmp_idx_ff + ONE_CNT;
            if (kind_ff == KIND_ADD && (cmp_idx_ff >= count_ff) && count_ff < MAX_CNT) begin
               mem_we = 1'b1;
            end
         end
         S_SHIFT: rd_addr = sh_idx_ff;
         S_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = sh_idx_ff - ONE_CNT;
            mem_wdata = mem_q_ff;
         end
         default: rd_addr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr[IDX_W-1:0]] <= mem_wdata;
      end
      if (rd_addr < MAX_CNT) begin
         mem_q_ff <= mem[rd_addr[IDX_W-1:0]];
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= '0;
         net_id_ff   <= NET_ID_RESET;
         cmd_type_ff <= '0;
         ack_type_ff <= '0;
         unblock_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDR:   own_addr_ff <= csr_wdata[AddrW-1:0];
            CSR_NETWORK_ID: net_id_ff   <= csr_wdata[TagW-1:0];
            CSR_CMD_TYPE:   cmd_type_ff <= csr_wdata[ByteW-1:0];
            CSR_ACK_TYPE:   ack_type_ff <= csr_wdata[ByteW-1:0];
            CSR_UNBLOCK:    unblock_ff  <= csr_wdata[ByteW-1:0];
            default: ;
         endcase
      end
   end

   // request sequencer and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pkt_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  kind_ff    <= req_ch.kind;
                  tag_ff     <= req_ch.net_tag;
                  key_ff     <= req_ch.node_addr;
                  dest_ff    <= req_ch.dest_addr;
                  ptype_ff   <= req_ch.pkt_type;
                  pay0_ff    <= req_ch.first_payload;
                  cmp_idx_ff <= '0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (kind_ff == KIND_PACKET && tag_ff != net_id_ff) begin
                  res_status_ff  <= ST_FOREIGN;
                  res_deliver_ff <= 1'b0;
                  state_ff       <= S_DONE;
               end else if (kind_ff != KIND_PACKET && kind_ff != KIND_ADD &&
                            kind_ff != KIND_REMOVE) begin
                  res_status_ff  <= ST_FOREIGN;
                  res_deliver_ff <= 1'b0;
                  state_ff       <= S_DONE;
               end else if (!scan_end) begin
                  cmp_idx_ff <= cmp_idx_ff + ONE_CNT;
               end else begin
                  case (kind_ff)
                     KIND_PACKET: begin
                        state_ff   <= S_DONE;
                        pkt_cnt_ff <= pkt_cnt_ff + CntW'(1);
                        if (!found) begin
                           res_status_ff  <= ST_DELIVERED;
                           res_deliver_ff <= 1'b1;
                        end else if (override_ok) begin
                           res_status_ff  <= ST_OVERRIDE;
                           res_deliver_ff <= 1'b1;
                        end else begin
                           res_status_ff  <= ST_BLOCKED;
                           res_deliver_ff <= 1'b0;
                        end
                     end
                     KIND_ADD: begin
                        state_ff       <= S_DONE;
                        res_deliver_ff <= 1'b0;
                        if (found) begin
                           res_status_ff <= ST_DUPLICATE;
                        end else if (count_ff < MAX_CNT) begin
                           count_ff      <= count_ff + ONE_CNT;
                           res_status_ff <= ST_ADDED;
                        end else begin
                           res_status_ff <= ST_FULL;
                        end
                     end
                     default: begin
                        res_deliver_ff <= 1'b0;
                        if (found) begin
                           sh_idx_ff <= cmp_idx_ff + ONE_CNT;
                           state_ff  <= S_SHIFT;
                        end else begin
                           res_status_ff <= ST_ABSENT;
                           state_ff      <= S_DONE;
                        end
                     end
                  endcase
               end
            end
            S_SHIFT: begin
               if (sh_idx_ff < count_ff) begin
                  state_ff <= S_SHIFT_WR;
               end else begin
                  count_ff      <= count_ff - ONE_CNT;
                  res_status_ff <= ST_REMOVED;
                  state_ff      <= S_DONE;
               end
            end
            S_SHIFT_WR: begin
               sh_idx_ff <= sh_idx_ff + ONE_CNT;
               state_ff  <= S_SHIFT;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_deliver_ff <= res_deliver_ff;
                  rsp_size_ff    <= size_ext[SizeW-1:0];
                  rsp_total_ff   <= pkt_cnt_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.deliver        = rsp_deliver_ff;
   assign rsp_ch.list_size      = rsp_size_ff;
   assign rsp_ch.received_total = rsp_total_ff;

endmodule

// File: hw/rtl/pbf_checker.sv
// Port-level checker for the sender block filter, bound to the top level.
// Depends on pbf_pkg and packet_sender_block_filter_defines.svh.
`include "packet_sender_block_filter_defines.svh"

module pbf_checker
   import pbf_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [StatusW-1:0] rsp_status,
   input logic               rsp_deliver,
   input logic [SizeW-1:0]   rsp_list_size
);

   `PBF_ASSERT_ALWAYS(a_reset_clears_rsp, reset, !rsp_valid)
   `PBF_ASSERT_NEXT(a_rsp_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))
   `PBF_ASSERT_SAME(a_deliver_status, rsp_valid && rsp_deliver, rsp_status == ST_DELIVERED || rsp_status == ST_OVERRIDE)
   `PBF_ASSERT_SAME(a_added_nonempty, rsp_valid && rsp_status == ST_ADDED, rsp_list_size != '0)
   `PBF_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind packet_sender_block_filter pbf_checker u_pbf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_deliver   (rsp_ch.deliver),
   .rsp_list_size (rsp_ch.list_size)
);

// File: sim/tb_packet_sender_block_filter.sv
// Testbench of the sender block filter: directed and random requests against a
// built-in model of the block list, packet counter and delivery decision.
// Depends on pbf_pkg, the channel interfaces in pbf_if.sv and the top level.
module tb_packet_sender_block_filter;
   import pbf_pkg::*;

   localparam kind_type KIND_UNUSED = 2'd3;
   localparam int       PoolSize    = 12;

   typedef struct {
      kind_type           kind;
      logic [TagW-1:0]    net_tag;
      logic [AddrW-1:0]   node_addr;
      logic [AddrW-1:0]   dest_addr;
      logic [ByteW-1:0]   pkt_type;
      logic [ByteW-1:0]   first_payload;
   } filter_req_type;

   typedef struct {
      status_type         status;
      logic               deliver;
      logic [SizeW-1:0]   list_size;
      logic [CntW-1:0]    received_total;
   } filter_verdict_type;

   logic                clock;
   logic                reset;
   logic                csr_we;
   csr_idx_type         csr_index;
   logic [CsrDataW-1:0] csr_wdata;

   pbf_req_if req_ch ();
   pbf_rsp_if rsp_ch ();

   packet_sender_block_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model copy of registers and state
   logic [AddrW-1:0]  own_addr_q;
   logic [TagW-1:0]   net_id_q;
   logic [ByteW-1:0]  cmd_type_q;
   logic [ByteW-1:0]  ack_type_q;
   logic [ByteW-1:0]  unblock_q;
   logic [AddrW-1:0]  blocked_senders[$];
   logic [CntW-1:0]   packet_count;

   filter_req_type       queued_requests[$];
   filter_verdict_type   awaited_verdicts[$];
   filter_req_type       on_wire;
   filter_req_type       next_req;
   filter_verdict_type   exp_v;
   int                verdict_tally[9];
   int                errors;
   int                accepted;
   int                src_gap;
   int                sink_hold;
   bit                steady;
   bit                long_stall_due;

   logic [AddrW-1:0]  addr_pool[PoolSize] = '{8'h00, 8'hff, 8'h01, 8'h02, 8'h03, 8'h10,
                                              8'h22, 8'h5a, 8'h7f, 8'h80, 8'ha5, 8'hc3};

   always #1 clock = ~clock;

   function automatic int find_sender(input logic [AddrW-1:0] addr);
      for (int i = 0; i < blocked_senders.size(); i++)
         if (blocked_senders[i] == addr) return i;
      return -1;
   endfunction

   function automatic filter_verdict_type apply_filter_request(input filter_req_type r);
      filter_verdict_type v;
      int              pos;
      v.status  = ST_FOREIGN;
      v.deliver = 1'b0;
      pos = find_sender(r.node_addr);
      case (r.kind)
         KIND_PACKET: begin
            if (r.net_tag == net_id_q) begin
               packet_count = packet_count + CntW'(1);
               if (pos < 0) begin
                  v.status  = ST_DELIVERED;
                  v.deliver = 1'b1;
               end else if (r.dest_addr == own_addr_q &&
                            (r.pkt_type == cmd_type_q || r.pkt_type == ack_type_q) &&
                            r.first_payload == unblock_q) begin
                  v.status  = ST_OVERRIDE;
                  v.deliver = 1'b1;
               end else begin
                  v.status = ST_BLOCKED;
               end
            end
         end
         KIND_ADD: begin
            if (pos >= 0) begin
               v.status = ST_DUPLICATE;
            end else if (blocked_senders.size() < DefMaxEntries) begin
               blocked_senders.push_back(r.node_addr);
               v.status = ST_ADDED;
            end else begin
               v.status = ST_FULL;
            end
         end
         KIND_REMOVE: begin
            if (pos >= 0) begin
               blocked_senders.delete(pos);
               v.status = ST_REMOVED;
            end else begin
               v.status = ST_ABSENT;
            end
         end
         default: ;
      endcase
      v.list_size      = SizeW'(blocked_senders.size());
      v.received_total = packet_count;
      verdict_tally[v.status]++;
      return v;
   endfunction

   function automatic filter_req_type make_req(input kind_type k, input logic [TagW-1:0] tag,
                                               input logic [AddrW-1:0] node,
                                               input logic [AddrW-1:0] dest,
                                               input logic [ByteW-1:0] ptype,
                                               input logic [ByteW-1:0] pay);
      filter_req_type r;
      r.kind          = k;
      r.net_tag       = tag;
      r.node_addr     = node;
      r.dest_addr     = dest;
      r.pkt_type      = ptype;
      r.first_payload = pay;
      return r;
   endfunction

   // mostly same-network packets and list edits on a small address pool
   function automatic filter_req_type random_request();
      filter_req_type r;
      int          pick;
      pick = $urandom_range(0, 99);
      r.kind = (pick < 55) ? KIND_PACKET : (pick < 80) ? KIND_ADD :
               (pick < 96) ? KIND_REMOVE : KIND_UNUSED;
      r.net_tag   = ($urandom_range(0, 7) == 0) ? TagW'($urandom) : net_id_q;
      r.node_addr = ($urandom_range(0, 3) == 0) ? AddrW'($urandom)
                                                : addr_pool[$urandom_range(0, PoolSize-1)];
      r.dest_addr = $urandom_range(0, 1) ? own_addr_q : AddrW'($urandom);
      case ($urandom_range(0, 2))
         0: r.pkt_type = cmd_type_q;
         1: r.pkt_type = ack_type_q;
         default: r.pkt_type = ByteW'($urandom);
      endcase
      r.first_payload = $urandom_range(0, 1) ? unblock_q : ByteW'($urandom);
      return r;
   endfunction

   task automatic program_csr(input csr_idx_type idx, input logic [CsrDataW-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_OWN_ADDR:   own_addr_q = val[AddrW-1:0];
         CSR_NETWORK_ID: net_id_q   = val;
         CSR_CMD_TYPE:   cmd_type_q = val[ByteW-1:0];
         CSR_ACK_TYPE:   ack_type_q = val[ByteW-1:0];
         CSR_UNBLOCK:    unblock_q  = val[ByteW-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [7:0] own, input logic [15:0] net,
                                input logic [7:0] cmd, input logic [7:0] ack,
                                input logic [7:0] unb);
      program_csr(CSR_OWN_ADDR, {8'h00, own});
      program_csr(CSR_NETWORK_ID, net);
      program_csr(CSR_CMD_TYPE, {8'h00, cmd});
      program_csr(CSR_ACK_TYPE, {8'h00, ack});
      program_csr(CSR_UNBLOCK, {8'h00, unb});
      csr_we <= 1'b0;
   endtask

   // sampled between edges so the driver's updates are settled
   task automatic wait_idle();
      while (queued_requests.size() != 0 || req_ch.valid || awaited_verdicts.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            awaited_verdicts.push_back(apply_filter_request(on_wire));
            accepted++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_ch.valid <= 1'b0;
            end else if (!steady && $urandom_range(0, 11) == 0) begin
               src_gap = $urandom_range(0, 17);
               req_ch.valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               next_req = queued_requests.pop_front();
               on_wire  = next_req;
               req_ch.valid         <= 1'b1;
               req_ch.kind          <= next_req.kind;
               req_ch.net_tag       <= next_req.net_tag;
               req_ch.node_addr     <= next_req.node_addr;
               req_ch.dest_addr     <= next_req.dest_addr;
               req_ch.pkt_type      <= next_req.pkt_type;
               req_ch.first_payload <= next_req.first_payload;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         sink_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_verdicts.size() == 0) begin
               $display("%0t: unexpected response, status %0d", $time, rsp_ch.status);
               errors++;
            end else begin
               exp_v = awaited_verdicts.pop_front();
               if (rsp_ch.status !== exp_v.status) begin
                  $display("%0t: status expected %0d got %0d", $time, exp_v.status,
                           rsp_ch.status);
                  errors++;
               end
               if (rsp_ch.deliver !== exp_v.deliver) begin
                  $display("%0t: deliver expected %0d got %0d", $time, exp_v.deliver,
                           rsp_ch.deliver);
                  errors++;
               end
               if (rsp_ch.list_size !== exp_v.list_size) begin
                  $display("%0t: list_size expected %0d got %0d", $time, exp_v.list_size,
                           rsp_ch.list_size);
                  errors++;
               end
               if (rsp_ch.received_total !== exp_v.received_total) begin
                  $display("%0t: received_total expected %0d got %0d", $time,
                           exp_v.received_total, rsp_ch.received_total);
                  errors++;
               end
            end
         end
         if (long_stall_due) begin
            sink_hold = 400;
            long_stall_due = 0;
         end
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_ch.ready <= 1'b0;
         end else if (!steady && $urandom_range(0, 9) == 0) begin
            sink_hold = $urandom_range(0, 17);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_OWN_ADDR;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.kind = KIND_PACKET;
      req_ch.net_tag = '0;
      req_ch.node_addr = '0;
      req_ch.dest_addr = '0;
      req_ch.pkt_type = '0;
      req_ch.first_payload = '0;
      rsp_ch.ready = 1'b0;
      own_addr_q = '0;
      net_id_q = NET_ID_RESET;
      cmd_type_q = '0;
      ack_type_q = '0;
      unblock_q = '0;
      packet_count = '0;
      errors = 0;
      accepted = 0;
      steady = 0;
      long_stall_due = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_settings(8'h12, 16'hAFFE, 8'h10, 8'h11, 8'h55);
      queued_requests.push_back(make_req(KIND_PACKET, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hFFFF, 8'hff, 8'hff, 8'hff, 8'hff));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'h00, 8'hff, 8'hff, 8'hff));
      queued_requests.push_back(make_req(KIND_REMOVE, 16'h0000, 8'h33, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_ADD, 16'hFFFF, 8'hff, 8'hff, 8'hff, 8'hff));
      queued_requests.push_back(make_req(KIND_ADD, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
      for (int a = 1; a <= 8; a++)
         queued_requests.push_back(make_req(KIND_ADD, 16'h1234, AddrW'(a), 8'h00, 8'h00,
                                            8'h00));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'h00, 8'h12, 8'h10, 8'h55));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'hff, 8'h12, 8'h11, 8'h55));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'h03, 8'h13, 8'h10, 8'h55));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'h03, 8'h12, 8'h12, 8'h55));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'h03, 8'h12, 8'h10, 8'h54));
      queued_requests.push_back(make_req(KIND_UNUSED, 16'hAFFE, 8'h03, 8'h12, 8'h10, 8'h55));
      queued_requests.push_back(make_req(KIND_REMOVE, 16'h0000, 8'h03, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_REMOVE, 16'h0000, 8'h03, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_REMOVE, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_REMOVE, 16'h0000, 8'h07, 8'h00, 8'h00, 8'h00));
      queued_requests.push_back(make_req(KIND_PACKET, 16'hAFFE, 8'h03, 8'h12, 8'h10, 8'h55));
      queued_requests.push_back(make_req(KIND_ADD, 16'h0000, 8'h03, 8'h00, 8'h00, 8'h00));
      wait_idle();

      load_settings(8'hff, 16'hFFFF, 8'hff, 8'h00, 8'hff);
      for (int n = 0; n < 250; n++) queued_requests.push_back(random_request());
      repeat (30) @(posedge clock);
      long_stall_due = 1;
      wait_idle();

      load_settings(8'h00, 16'h0000, 8'h00, 8'hff, 8'h00);
      for (int n = 0; n < 250; n++) queued_requests.push_back(random_request());
      wait_idle();

      load_settings(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      steady = 1;
      for (int n = 0; n < 250; n++) queued_requests.push_back(random_request());
      wait_idle();

      $display("%0d requests, 4 register settings: %0d delivered, %0d override, %0d blocked,",
               accepted, verdict_tally[ST_DELIVERED], verdict_tally[ST_OVERRIDE],
               verdict_tally[ST_BLOCKED]);
      $display("%0d foreign, %0d added, %0d duplicate, %0d full, %0d removed, %0d absent",
               verdict_tally[ST_FOREIGN], verdict_tally[ST_ADDED], verdict_tally[ST_DUPLICATE],
               verdict_tally[ST_FULL], verdict_tally[ST_REMOVED], verdict_tally[ST_ABSENT]);
      if (errors == 0 && awaited_verdicts.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
